### hdl/dbts_pkg.sv
// ----------------------------------------------------------------------------
// dbts_pkg: shared types and constants
// Widths, window entry layout, handshake structs and sequencer states for the
// detection box temporal smoother.
// ----------------------------------------------------------------------------
package dbts_pkg;

	localparam int WINDOW_MAX = 16;
	localparam int SLOT_W     = $clog2(WINDOW_MAX);
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
	localparam int COORD_W    = 12;
	localparam int EDGE_W     = COORD_W + 1;
	localparam int SUM_W      = EDGE_W + SLOT_W;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS       = 2'd1;

	localparam logic [CFG_W-1:0] HISTORY_LENGTH_RST = 5'd5;
	localparam logic [CFG_W-1:0] MIN_HITS_RST       = 5'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [EDGE_W-1:0]  r;
		logic [EDGE_W-1:0]  b;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic              valid;
		entry_t            data;
	} win_wr_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} win_rd_t;

	typedef struct packed {
		logic   vld;
		logic   hit;
		entry_t data;
	} win_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DIV_GO,
		S_DIV_WAIT,
		S_DONE
	} state_t;

endpackage

### hdl/dbts_frame_if.sv
// ----------------------------------------------------------------------------
// dbts_frame_if: detection input channel
// One word per video frame: found flag and box.
// ----------------------------------------------------------------------------
interface dbts_frame_if;

	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [dbts_pkg::COORD_W-1:0] box_x;
	logic [dbts_pkg::COORD_W-1:0] box_y;
	logic [dbts_pkg::COORD_W-1:0] box_w;
	logic [dbts_pkg::COORD_W-1:0] box_h;

	modport source (output valid, found, box_x, box_y, box_w, box_h, input ready);
	modport sink   (input valid, found, box_x, box_y, box_w, box_h, output ready);

endinterface

### hdl/dbts_result_if.sv
// ----------------------------------------------------------------------------
// dbts_result_if: smoothed box output channel
// Mean box, hit count and show flag, one word per input frame.
// ----------------------------------------------------------------------------
interface dbts_result_if;

	logic                         valid;
	logic                         ready;
	logic                         show;
	logic [dbts_pkg::COORD_W-1:0] mean_x;
	logic [dbts_pkg::COORD_W-1:0] mean_y;
	logic [dbts_pkg::EDGE_W-1:0]  mean_w;
	logic [dbts_pkg::EDGE_W-1:0]  mean_h;
	logic [dbts_pkg::CNT_W-1:0]   hit_count;

	modport source (output valid, show, mean_x, mean_y, mean_w, mean_h, hit_count,
		input ready);
	modport sink   (input valid, show, mean_x, mean_y, mean_w, mean_h, hit_count,
		output ready);

endinterface

### hdl/dbts_window.sv
// ----------------------------------------------------------------------------
// dbts_window: frame history store
// Ring of box entries with a registered read port; per-slot valid flags are
// cleared by reset so the window starts empty.
// ----------------------------------------------------------------------------
module dbts_window (
	input  logic               clk,
	input  logic               arst_n,
	input  dbts_pkg::win_wr_t  wr,
	input  dbts_pkg::win_rd_t  rd,
	output dbts_pkg::win_rsp_t rsp
);

	dbts_pkg::entry_t                    mem [dbts_pkg::WINDOW_MAX];
	logic [dbts_pkg::WINDOW_MAX-1:0]     valid_q;
	dbts_pkg::entry_t                    rd_data_s1;
	logic                                rd_hit_s1;
	logic                                rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_s1 <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			rd_hit_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= wr.valid;
			end
			rd_vld_s1 <= rd.en;
			if (rd.en) begin
				rd_hit_s1 <= valid_q[rd.addr];
			end
		end
	end

	assign rsp.vld  = rd_vld_s1;
	assign rsp.hit  = rd_hit_s1;
	assign rsp.data = rd_data_s1;

endmodule

### hdl/dbts_div.sv
// ----------------------------------------------------------------------------
// dbts_div: serial restoring divider
// One quotient bit per cycle; the quotient is valid while done is high.
// ----------------------------------------------------------------------------
module dbts_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dbts_pkg::SUM_W-1:0]  dividend,
	input  logic [dbts_pkg::CNT_W-1:0]  divisor,
	output logic [dbts_pkg::SUM_W-1:0]  quotient,
	output dbts_pkg::div_stat_t         stat
);

	localparam int STEP_W = $clog2(dbts_pkg::SUM_W + 1);

	logic [dbts_pkg::SUM_W-1:0] quot_q;
	logic [dbts_pkg::CNT_W-1:0] rem_q;
	logic [dbts_pkg::CNT_W-1:0] div_q;
	logic [STEP_W-1:0]          step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [dbts_pkg::CNT_W:0]   trial;
	logic [dbts_pkg::CNT_W:0]   diff;
	logic                       ge;

	assign trial = {rem_q, quot_q[dbts_pkg::SUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits the narrower register
			rem_q  <= ge ? diff[dbts_pkg::CNT_W-1:0] : trial[dbts_pkg::CNT_W-1:0];
			quot_q <= {quot_q[dbts_pkg::SUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(dbts_pkg::SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quotient  = quot_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hdl/detection_box_temporal_smoother.sv
// ----------------------------------------------------------------------------
// detection_box_temporal_smoother: sliding-window box averaging
// Keeps the last history_length detections (at most 16) and gives the mean box of the valid ones.
// ----------------------------------------------------------------------------
// Usage:
//   frame   - one word per video frame (found, box_x/y/w/h), valid/ready.
//   result  - one word per frame: show, mean box, hit_count, valid/ready.
//   cfg_*   - write port: index 0 history_length, index 1 min_hits; write
//             only while no frame is in flight. Other indexes are ignored.
// Flow:
//   An accepted frame is written to the window, which is then scanned one
//   entry read a cycle, and the shared serial divider is run four times at
//   one bit a cycle to turn the sums into means; the divider is skipped
//   when the window holds no valid entry.
//   frame.ready is high only while the sequencer is idle, from the cycle
//   after the result register loads, so a new frame is taken only once the
//   result of the previous one has been loaded.
// Reset:
//   The window is empty, the ring pointer and fill level are zero, and the
//   registers return to history_length 5, min_hits 3.
// Stall:
//   A result waits in the output register; the next frame is still
//   accepted, and its result holds until the pending word is taken.
// ----------------------------------------------------------------------------
module detection_box_temporal_smoother (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dbts_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [dbts_pkg::CFG_W-1:0]     cfg_data,
	dbts_frame_if.sink                     frame,
	dbts_result_if.source                  result
);

	localparam logic [dbts_pkg::CNT_W-1:0] LEN_MAX = dbts_pkg::CNT_W'(dbts_pkg::WINDOW_MAX);

	dbts_pkg::state_t               state_q, state_d;
	logic [dbts_pkg::CFG_W-1:0]     hist_q;
	logic [dbts_pkg::CFG_W-1:0]     minh_q;
	logic [dbts_pkg::SLOT_W-1:0]    slot_q;
	logic [dbts_pkg::SLOT_W-1:0]    cur_slot_q;
	logic [dbts_pkg::CNT_W-1:0]     fill_q;
	logic [dbts_pkg::CNT_W-1:0]     scan_q;
	logic [dbts_pkg::CNT_W-1:0]     count_q;
	logic [dbts_pkg::SUM_W-1:0]     sx_q, sy_q, sr_q, sb_q;
	logic [1:0]                     div_sel_q;
	logic [dbts_pkg::COORD_W-1:0]   qx_q, qy_q;
	logic [dbts_pkg::EDGE_W-1:0]    qr_q, qb_q;

	logic                           out_valid_q;
	logic                           show_q;
	logic [dbts_pkg::COORD_W-1:0]   mean_x_q, mean_y_q;
	logic [dbts_pkg::EDGE_W-1:0]    mean_w_q, mean_h_q;
	logic [dbts_pkg::CNT_W-1:0]     hit_count_q;

	dbts_pkg::win_wr_t              win_wr;
	dbts_pkg::win_rd_t              win_rd;
	dbts_pkg::win_rsp_t             win_rsp;
	dbts_pkg::div_stat_t            div_stat;
	logic                           div_start;
	logic [dbts_pkg::SUM_W-1:0]     div_dividend;
	logic [dbts_pkg::SUM_W-1:0]     div_quot;

	logic                           accept;
	logic                           scan_more;
	logic                           load_out;
	logic [dbts_pkg::CNT_W-1:0]     len_eff;
	logic [dbts_pkg::CNT_W-1:0]     fill_inc;
	logic [dbts_pkg::EDGE_W-1:0]    aw, ah;
	logic                           box_ok;

	assign accept    = frame.valid && frame.ready;
	assign scan_more = scan_q < fill_q;
	assign load_out  = (state_q == dbts_pkg::S_DONE) && (!out_valid_q || result.ready);
	assign len_eff   = (hist_q > LEN_MAX) ? LEN_MAX : hist_q;
	assign fill_inc  = fill_q + dbts_pkg::CNT_W'(1);
	assign box_ok    = frame.found && (frame.box_w != '0) && (frame.box_h != '0);

	// edge means are never below the corner means
	assign aw = qr_q - {1'b0, qx_q};
	assign ah = qb_q - {1'b0, qy_q};

	// write the frame's entry straight from the channel on acceptance
	always_comb begin
		win_wr.en     = accept;
		win_wr.addr   = slot_q;
		win_wr.valid  = box_ok;
		win_wr.data.x = frame.box_x;
		win_wr.data.y = frame.box_y;
		win_wr.data.r = {1'b0, frame.box_x} + {1'b0, frame.box_w};
		win_wr.data.b = {1'b0, frame.box_y} + {1'b0, frame.box_h};
		win_rd.en     = (state_q == dbts_pkg::S_SCAN) && scan_more;
		win_rd.addr   = cur_slot_q - scan_q[dbts_pkg::SLOT_W-1:0];
	end

	always_comb begin
		case (div_sel_q)
			2'd0:    div_dividend = sx_q;
			2'd1:    div_dividend = sy_q;
			2'd2:    div_dividend = sr_q;
			default: div_dividend = sb_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		frame.ready = 1'b0;
		div_start   = 1'b0;
		unique case (state_q)
			dbts_pkg::S_IDLE: begin
				frame.ready = 1'b1;
				if (frame.valid) begin
					state_d = dbts_pkg::S_SCAN;
				end
			end
			dbts_pkg::S_SCAN: begin
				if (!scan_more) begin
					state_d = dbts_pkg::S_DRAIN;
				end
			end
			dbts_pkg::S_DRAIN: begin
				state_d = dbts_pkg::S_DIV_GO;
			end
			dbts_pkg::S_DIV_GO: begin
				if (count_q == '0) begin
					state_d = dbts_pkg::S_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = dbts_pkg::S_DIV_WAIT;
				end
			end
			dbts_pkg::S_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = (div_sel_q == 2'd3) ? dbts_pkg::S_DONE : dbts_pkg::S_DIV_GO;
				end
			end
			dbts_pkg::S_DONE: begin
				if (load_out) begin
					state_d = dbts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dbts_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= dbts_pkg::HISTORY_LENGTH_RST;
			minh_q      <= dbts_pkg::MIN_HITS_RST;
			slot_q      <= '0;
			cur_slot_q  <= '0;
			fill_q      <= '0;
			scan_q      <= '0;
			count_q     <= '0;
			div_sel_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					dbts_pkg::REG_HISTORY_LENGTH: hist_q <= cfg_data;
					dbts_pkg::REG_MIN_HITS:       minh_q <= cfg_data;
					default:                      ;
				endcase
			end
			if (accept) begin
				cur_slot_q <= slot_q;
				slot_q     <= slot_q + dbts_pkg::SLOT_W'(1);
				fill_q     <= (fill_inc > len_eff) ? len_eff : fill_inc;
				scan_q     <= '0;
				count_q    <= '0;
				div_sel_q  <= '0;
			end
			if (win_rd.en) begin
				scan_q <= scan_q + dbts_pkg::CNT_W'(1);
			end
			if (win_rsp.vld && win_rsp.hit) begin
				count_q <= count_q + dbts_pkg::CNT_W'(1);
			end
			if ((state_q == dbts_pkg::S_DIV_WAIT) && div_stat.done) begin
				div_sel_q <= div_sel_q + 2'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// accumulate corner and edge sums and park quotients; payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= '0;
			sy_q <= '0;
			sr_q <= '0;
			sb_q <= '0;
		end else if (win_rsp.vld && win_rsp.hit) begin
			sx_q <= sx_q + dbts_pkg::SUM_W'(win_rsp.data.x);
			sy_q <= sy_q + dbts_pkg::SUM_W'(win_rsp.data.y);
			sr_q <= sr_q + dbts_pkg::SUM_W'(win_rsp.data.r);
			sb_q <= sb_q + dbts_pkg::SUM_W'(win_rsp.data.b);
		end
		if ((state_q == dbts_pkg::S_DIV_WAIT) && div_stat.done) begin
			case (div_sel_q)
				2'd0:    qx_q <= div_quot[dbts_pkg::COORD_W-1:0];
				2'd1:    qy_q <= div_quot[dbts_pkg::COORD_W-1:0];
				2'd2:    qr_q <= div_quot[dbts_pkg::EDGE_W-1:0];
				default: qb_q <= div_quot[dbts_pkg::EDGE_W-1:0];
			endcase
		end
		if (load_out) begin
			hit_count_q <= count_q;
			if (count_q == '0) begin
				show_q   <= 1'b0;
				mean_x_q <= '0;
				mean_y_q <= '0;
				mean_w_q <= '0;
				mean_h_q <= '0;
			end else begin
				show_q   <= (count_q >= minh_q) && (aw != '0) && (ah != '0);
				mean_x_q <= qx_q;
				mean_y_q <= qy_q;
				mean_w_q <= aw;
				mean_h_q <= ah;
			end
		end
	end

	dbts_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (win_wr),
		.rd     (win_rd),
		.rsp    (win_rsp)
	);

	dbts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	assign result.valid     = out_valid_q;
	assign result.show      = show_q;
	assign result.mean_x    = mean_x_q;
	assign result.mean_y    = mean_y_q;
	assign result.mean_w    = mean_w_q;
	assign result.mean_h    = mean_h_q;
	assign result.hit_count = hit_count_q;

endmodule
